[rtl/ihd_pkg.sv]
// ----------------------------------------------------------------------------
// ihd_pkg
// Shared types, constants and the CRC-16-CCITT byte update for the IBM
// sector header detector.
// ----------------------------------------------------------------------------
package ihd_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int TIME_W        = 32;
    localparam int PADDR_W       = 5;

    localparam logic [3:0]  POS_IDLE  = 4'd15;
    localparam logic [3:0]  MFM_LAST  = 4'd9;
    localparam logic [3:0]  FM_LAST   = 4'd7;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  SYNC_MARK = 8'hA1;
    localparam logic [7:0]  ID_MARK   = 8'hFE;
    localparam logic [7:0]  COUNT_MAX = 8'hFF;

    localparam logic [2:0] REG_FM_MODE     = 3'd0;
    localparam logic [2:0] REG_TGT_CYL     = 3'd1;
    localparam logic [2:0] REG_TGT_HEAD    = 3'd2;
    localparam logic [2:0] REG_TGT_SECTOR  = 3'd3;
    localparam logic [2:0] REG_TGT_SIZE    = 3'd4;

    typedef struct packed {
        logic              func;
        logic [7:0]        data_byte;
        logic              window_start;
        logic [TIME_W-1:0] tick_stamp;
    } t_in_item;

    typedef struct packed {
        logic       fm_mode;
        logic [7:0] target_cylinder;
        logic [7:0] target_head;
        logic [7:0] target_sector;
        logic [7:0] target_size_code;
    } t_cfg;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] mfm_mark(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd3:    m = ID_MARK;
            default: m = SYNC_MARK;
        endcase
        return m;
    endfunction

endpackage

[rtl/ihd_if.sv]
// ----------------------------------------------------------------------------
// ihd_if
// Valid/ready channels of the sector header detector: byte/index items in,
// header reports out.
// ----------------------------------------------------------------------------
interface ihd_in_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [7:0]                data_byte;
    logic                      window_start;
    logic [ihd_pkg::TIME_W-1:0] tick_stamp;

    modport source (output valid, func, data_byte, window_start, tick_stamp, input ready);
    modport sink   (input valid, func, data_byte, window_start, tick_stamp, output ready);
endinterface

interface ihd_out_if;
    logic                      valid;
    logic                      ready;
    logic                      header_ok;
    logic                      target_match;
    logic [7:0]                cylinder;
    logic [7:0]                head;
    logic [7:0]                sector;
    logic [7:0]                size_code;
    logic [ihd_pkg::TIME_W-1:0] ticks_since_index;
    logic [7:0]                header_count;

    modport source (output valid, header_ok, target_match, cylinder, head, sector,
                    size_code, ticks_since_index, header_count, input ready);
    modport sink   (input valid, header_ok, target_match, cylinder, head, sector,
                    size_code, ticks_since_index, header_count, output ready);
endinterface

[rtl/ihd_apb_regs.sv]
// ----------------------------------------------------------------------------
// ihd_apb_regs
// APB register file: read mode and target sector ID.
// ----------------------------------------------------------------------------
module ihd_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ihd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output ihd_pkg::t_cfg                o_cfg
);

    ihd_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ihd_pkg::PADDR_W-1:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                ihd_pkg::REG_FM_MODE:    r_cfg.fm_mode          <= pwdata[0];
                ihd_pkg::REG_TGT_CYL:    r_cfg.target_cylinder  <= pwdata[7:0];
                ihd_pkg::REG_TGT_HEAD:   r_cfg.target_head      <= pwdata[7:0];
                ihd_pkg::REG_TGT_SECTOR: r_cfg.target_sector    <= pwdata[7:0];
                ihd_pkg::REG_TGT_SIZE:   r_cfg.target_size_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ihd_pkg::REG_FM_MODE:    prdata = {31'd0, r_cfg.fm_mode};
            ihd_pkg::REG_TGT_CYL:    prdata = {24'd0, r_cfg.target_cylinder};
            ihd_pkg::REG_TGT_HEAD:   prdata = {24'd0, r_cfg.target_head};
            ihd_pkg::REG_TGT_SECTOR: prdata = {24'd0, r_cfg.target_sector};
            ihd_pkg::REG_TGT_SIZE:   prdata = {24'd0, r_cfg.target_size_code};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

[rtl/ihd_in_stage.sv]
// ----------------------------------------------------------------------------
// ihd_in_stage
// Input register: captures one item per transfer, holds it while the core
// stalls.
// ----------------------------------------------------------------------------
module ihd_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ihd_in_if.sink            i_in,
    input  logic              i_adv,
    output logic              o_valid,
    output ihd_pkg::t_in_item o_item
);

    logic              r_valid;
    ihd_pkg::t_in_item r_item;
    logic              take;

    assign take       = !r_valid || i_adv;
    assign i_in.ready = take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in.valid) begin
            r_item.func         <= i_in.func;
            r_item.data_byte    <= i_in.data_byte;
            r_item.window_start <= i_in.window_start;
            r_item.tick_stamp   <= i_in.tick_stamp;
        end
    end

endmodule

[rtl/ihd_core.sv]
// ----------------------------------------------------------------------------
// ihd_core
// Header window tracking, mark and CRC checks, ID capture, index timing and
// the result register.
// ----------------------------------------------------------------------------
module ihd_core #(
    parameter int TIME_BITS = ihd_pkg::TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ihd_pkg::t_in_item i_item,
    input  ihd_pkg::t_cfg     i_cfg,
    output logic              o_adv,
    ihd_out_if.source         o_out
);

    logic [3:0]           r_pos,  n_pos;
    logic [15:0]          r_crc,  n_crc;
    logic                 r_marks, n_marks;
    logic [7:0]           r_id [4];
    logic [7:0]           n_id [4];
    logic [TIME_BITS-1:0] r_idx,  n_idx;
    logic [TIME_BITS-1:0] r_win,  n_win;
    logic [7:0]           r_cnt,  n_cnt;

    logic                 r_out_valid;
    logic                 r_out_ok;
    logic                 r_out_match;
    logic [7:0]           r_out_id [4];
    logic [ihd_pkg::TIME_W-1:0] r_out_ticks;
    logic [7:0]           r_out_cnt;

    logic                 adv;
    logic                 fire;
    logic                 n_result;
    logic [TIME_BITS-1:0] now;
    logic [3:0]           w_pos;
    logic [3:0]           w_last;
    logic [15:0]          w_crc_in;
    logic [15:0]          w_crc_b;
    logic                 w_ok;
    logic                 w_match;
    logic [TIME_BITS-1:0] w_diff;
    logic [7:0]           b;

    assign adv   = !r_out_valid || o_out.ready;
    assign fire  = i_valid && adv;
    assign o_adv = adv;
    assign now   = TIME_BITS'(i_item.tick_stamp);
    assign b     = i_item.data_byte;

    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_marks  = r_marks;
        n_id     = r_id;
        n_idx    = r_idx;
        n_win    = r_win;
        n_cnt    = r_cnt;
        n_result = 1'b0;
        w_pos    = i_item.window_start ? 4'd0 : r_pos;
        w_crc_in = i_item.window_start ? ihd_pkg::CRC_INIT : r_crc;
        w_crc_b  = ihd_pkg::crc_byte(w_crc_in, b);
        w_last   = i_cfg.fm_mode ? ihd_pkg::FM_LAST : ihd_pkg::MFM_LAST;
        w_ok     = 1'b0;
        if (fire) begin
            if (i_item.func) begin
                n_idx = now;
                n_cnt = 8'd0;
            end else if (i_item.window_start || r_pos != ihd_pkg::POS_IDLE) begin
                if (i_item.window_start) begin
                    n_marks = 1'b1;
                    n_win   = now;
                end
                if (i_cfg.fm_mode) begin
                    n_crc = (w_pos >= 4'd1) ? w_crc_b : w_crc_in;
                    if (w_pos == 4'd1 && b != ihd_pkg::ID_MARK) begin
                        n_marks = 1'b0;
                    end
                    if (w_pos >= 4'd2 && w_pos <= 4'd5) begin
                        n_id[2'(w_pos - 4'd2)] = b;
                    end
                end else begin
                    n_crc = w_crc_b;
                    if (w_pos <= 4'd3 && b != ihd_pkg::mfm_mark(w_pos[1:0])) begin
                        n_marks = 1'b0;
                    end
                    if (w_pos >= 4'd4 && w_pos <= 4'd7) begin
                        n_id[w_pos[1:0]] = b;
                    end
                end
                if (w_pos < w_last) begin
                    n_pos = w_pos + 4'd1;
                end else begin
                    n_pos    = ihd_pkg::POS_IDLE;
                    n_result = 1'b1;
                    w_ok     = n_marks && (n_crc == 16'd0);
                    if (w_ok && r_cnt != ihd_pkg::COUNT_MAX) begin
                        n_cnt = r_cnt + 8'd1;
                    end
                end
            end
        end
    end

    assign w_match = w_ok
                  && n_id[0] == i_cfg.target_cylinder
                  && n_id[1] == i_cfg.target_head
                  && n_id[2] == i_cfg.target_sector
                  && n_id[3] == i_cfg.target_size_code;
    assign w_diff  = n_win - r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= ihd_pkg::POS_IDLE;
            r_crc       <= ihd_pkg::CRC_INIT;
            r_marks     <= 1'b0;
            r_id        <= '{default: 8'd0};
            r_idx       <= '0;
            r_win       <= '0;
            r_cnt       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_marks <= n_marks;
            r_id    <= n_id;
            r_idx   <= n_idx;
            r_win   <= n_win;
            r_cnt   <= n_cnt;
            if (adv) begin
                r_out_valid <= n_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_result) begin
            r_out_ok    <= w_ok;
            r_out_match <= w_match;
            r_out_id    <= n_id;
            r_out_ticks <= ihd_pkg::TIME_W'(w_diff);
            r_out_cnt   <= n_cnt;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.header_ok         = r_out_ok;
    assign o_out.target_match      = r_out_match;
    assign o_out.cylinder          = r_out_id[0];
    assign o_out.head              = r_out_id[1];
    assign o_out.sector            = r_out_id[2];
    assign o_out.size_code         = r_out_id[3];
    assign o_out.ticks_since_index = r_out_ticks;
    assign o_out.header_count      = r_out_cnt;

    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_result |=> r_out_valid)
        else $error("result not registered");

    a_idle_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_result |=> r_pos == ihd_pkg::POS_IDLE)
        else $error("window still open after its last byte");

    a_index_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_item.func) |=> r_cnt == 8'd0)
        else $error("header count not cleared by index");

    a_match_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_match) |-> r_out_ok)
        else $error("target match without valid header");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= ihd_pkg::MFM_LAST) || (r_pos == ihd_pkg::POS_IDLE))
        else $error("window position out of range");

endmodule

[rtl/ibm_sector_header_detector.sv]
// ----------------------------------------------------------------------------
// ibm_sector_header_detector
// Finds IBM ID address marks (MFM or FM) in a decoded byte stream and
// reports each header window with its ID, CRC status and index timing.
//
// i_in carries decoded bytes and index pulses; a byte with window_start set
// opens a header window (10 bytes MFM, 8 bytes FM, chosen by fm_mode).
// o_out carries one report per completed window; other items give none.
// The APB port holds fm_mode and the target ID; write it only while idle.
// An item can transfer in every cycle unless o_out stalls; the report of a
// window passes from its last byte through the input register, then the
// result register, to o_out.
// When o_out stalls, the result register holds and i_in keeps taking items
// until the input register is also full.
// Reset (synchronous, active low) closes any window, clears the header
// count, index and window times, and empties both registers.
// Ticks are measured modulo 2^TIME_BITS and returned as 32 bits.
// ----------------------------------------------------------------------------
module ibm_sector_header_detector #(
    parameter int TIME_BITS = ihd_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ihd_in_if.sink                       i_in,
    ihd_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ihd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    ihd_pkg::t_cfg     cfg;
    ihd_pkg::t_in_item s1_item;
    logic              s1_valid;
    logic              core_adv;

    ihd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ihd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (core_adv),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    ihd_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_item  (s1_item),
        .i_cfg   (cfg),
        .o_adv   (core_adv),
        .o_out   (o_out)
    );

endmodule

[tb/sv/ibm_sector_header_detector_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ibm_sector_header_detector_tb
// Self-checking bench for the IBM sector header detector. A shadow decoder
// follows every byte and index transfer (window position, CRC, ID bytes,
// index timing, per-revolution count) and queues the header report that it
// predicts. Each report from the block is compared field by field with the
// oldest prediction. Stimulus covers MFM and FM windows, restarts, index
// pulses inside windows and mode changes mid-window, with random source
// gaps, sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module ibm_sector_header_detector_tb;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int FM_RUN_HEADERS = 30;
    localparam int HOLD_HEADERS   = 30;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_PRINTS     = 100;

    typedef enum {FLAW_NONE, FLAW_BIT, FLAW_MARK} t_flaw;

    typedef struct {
        logic        header_ok;
        logic        target_match;
        logic [7:0]  cylinder;
        logic [7:0]  head;
        logic [7:0]  sector;
        logic [7:0]  size_code;
        logic [31:0] ticks_since_index;
        logic [7:0]  header_count;
    } t_header_report;

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ihd_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    ihd_in_if  in_if ();
    ihd_out_if out_if ();

    ibm_sector_header_detector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the detector
    ihd_pkg::t_cfg  cfg_shadow;
    logic [3:0]     win_pos;
    logic [15:0]    crc_acc;
    logic           marks_ok;
    logic [7:0]     id_seen [4];
    logic [31:0]    index_stamp;
    logic [31:0]    window_stamp;
    logic [7:0]     hdr_count;
    t_header_report expected_headers [$];

    // stimulus
    ihd_pkg::t_in_item pending_items [$];
    logic [7:0]        carry_bytes [$];
    logic [31:0]       tick_now;
    ihd_pkg::t_in_item tx_item = '0;
    bit                tx_busy;
    bit                in_taken;
    int                tx_wait;
    int                rx_wait;
    int                rx_hold;
    bit                src_steady;
    bit                sink_steady;
    int                idle_cycles;

    int n_pushed, n_in, n_used, n_reports, n_ok, n_match, n_mismatch;

    function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0} ^ (fb ? ihd_pkg::CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic void decode_shadow(input ihd_pkg::t_in_item it);
        logic [3:0]     pos;
        logic [3:0]     last_pos;
        logic           ok;
        t_header_report rpt;
        n_in++;
        if (it.func) begin
            index_stamp = it.tick_stamp;
            hdr_count   = '0;
            n_used++;
            return;
        end
        if (it.window_start) begin
            win_pos      = 4'd0;
            crc_acc      = ihd_pkg::CRC_INIT;
            marks_ok     = 1'b1;
            window_stamp = it.tick_stamp;
        end else if (win_pos == ihd_pkg::POS_IDLE) begin
            return;
        end
        n_used++;
        pos      = win_pos;
        last_pos = cfg_shadow.fm_mode ? ihd_pkg::FM_LAST : ihd_pkg::MFM_LAST;
        if (cfg_shadow.fm_mode) begin
            if (pos >= 4'd1) crc_acc = crc_next(crc_acc, it.data_byte);
            if (pos == 4'd1 && it.data_byte != ihd_pkg::ID_MARK) marks_ok = 1'b0;
            if (pos >= 4'd2 && pos <= 4'd5) id_seen[2'(pos - 4'd2)] = it.data_byte;
        end else begin
            crc_acc = crc_next(crc_acc, it.data_byte);
            if (pos <= 4'd3 && it.data_byte != (pos == 4'd3 ? ihd_pkg::ID_MARK
                                                             : ihd_pkg::SYNC_MARK))
                marks_ok = 1'b0;
            if (pos >= 4'd4 && pos <= 4'd7) id_seen[2'(pos - 4'd4)] = it.data_byte;
        end
        if (pos < last_pos) begin
            win_pos = pos + 4'd1;
            return;
        end
        win_pos = ihd_pkg::POS_IDLE;
        ok = marks_ok && crc_acc == 16'h0000;
        if (ok && hdr_count != ihd_pkg::COUNT_MAX) hdr_count++;
        rpt.header_ok         = ok;
        rpt.target_match      = ok && id_seen[0] == cfg_shadow.target_cylinder
                                && id_seen[1] == cfg_shadow.target_head
                                && id_seen[2] == cfg_shadow.target_sector
                                && id_seen[3] == cfg_shadow.target_size_code;
        rpt.cylinder          = id_seen[0];
        rpt.head              = id_seen[1];
        rpt.sector            = id_seen[2];
        rpt.size_code         = id_seen[3];
        rpt.ticks_since_index = window_stamp - index_stamp;
        rpt.header_count      = hdr_count;
        expected_headers.push_back(rpt);
    endfunction

    function automatic int draw_wait(input bit steady);
        return steady ? 0 : $urandom_range(16, 0);
    endfunction

    function automatic void push_item(input logic func, input logic [7:0] b, input logic start);
        ihd_pkg::t_in_item it;
        if ($urandom_range(49, 0) == 0) tick_now = $urandom();
        else tick_now = tick_now + $urandom_range(4000, 1);
        it.func         = func;
        it.data_byte    = b;
        it.window_start = start;
        it.tick_stamp   = tick_now;
        pending_items.push_back(it);
        n_pushed++;
    endfunction

    function automatic void push_index();
        push_item(1'b1, 8'($urandom), 1'($urandom_range(1, 0)));
    endfunction

    function automatic logic [31:0] pick_id();
        logic [31:0] t;
        t = {cfg_shadow.target_cylinder, cfg_shadow.target_head,
             cfg_shadow.target_sector, cfg_shadow.target_size_code};
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return t;
            4: begin
                t[8 * $urandom_range(3, 0) +: 8] = 8'($urandom);
                return t;
            end
            5: return $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_flaw pick_flaw();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70) return FLAW_NONE;
        return (r < 85) ? FLAW_BIT : FLAW_MARK;
    endfunction

    // Builds a header with a good CRC, then damages it as asked. Bytes from
    // 'keep' on are held back in carry_bytes to finish the window later.
    function automatic void push_header(input logic fm, input logic [31:0] idw,
                                        input t_flaw flaw, input int index_at,
                                        input int keep);
        logic [7:0]  hb [$];
        logic [15:0] c;
        int          k;
        c = ihd_pkg::CRC_INIT;
        if (fm) hb.push_back(8'($urandom));
        else repeat (3) hb.push_back(ihd_pkg::SYNC_MARK);
        hb.push_back(ihd_pkg::ID_MARK);
        for (k = 0; k < 4; k++) hb.push_back(idw[31 - 8 * k -: 8]);
        for (k = fm ? 1 : 0; k < hb.size(); k++) c = crc_next(c, hb[k]);
        hb.push_back(c[15:8]);
        hb.push_back(c[7:0]);
        if (flaw == FLAW_BIT) begin
            k = $urandom_range(hb.size() - 1, fm ? 1 : 0);
            hb[k] = hb[k] ^ (8'h01 << $urandom_range(7, 0));
        end else if (flaw == FLAW_MARK) begin
            k = fm ? 1 : $urandom_range(3, 0);
            hb[k] = hb[k] ^ 8'($urandom_range(255, 1));
        end
        for (k = 0; k < hb.size(); k++) begin
            if (k == index_at && k != 0) push_index();
            if (k < keep) push_item(1'b0, hb[k], k == 0);
            else carry_bytes.push_back(hb[k]);
        end
    endfunction

    function automatic void random_phase(input int n_items);
        int   goal;
        int   sel;
        int   len;
        logic fm;
        fm  = cfg_shadow.fm_mode;
        len = fm ? 8 : 10;
        // finish a window left open before the register update
        while (carry_bytes.size() != 0) push_item(1'b0, carry_bytes.pop_front(), 1'b0);
        goal = n_pushed + n_items;
        while (n_pushed < goal) begin
            sel = $urandom_range(99, 0);
            if (sel < 55) begin
                push_header(fm, pick_id(), pick_flaw(), 0, len);
            end else if (sel < 65) begin
                push_header(fm, pick_id(), pick_flaw(), $urandom_range(len - 1, 1), len);
            end else if (sel < 72) begin
                push_header(!fm, pick_id(), pick_flaw(), 0, fm ? 10 : 8);
            end else if (sel < 80) begin
                push_header(fm, pick_id(), FLAW_NONE, 0, $urandom_range(len - 1, 1));
                carry_bytes.delete();
            end else if (sel < 88) begin
                push_index();
            end else begin
                repeat ($urandom_range(6, 1))
                    push_item(1'b0, 8'($urandom), $urandom_range(9, 0) == 0);
            end
        end
        if ($urandom_range(4, 0) < 2)
            push_header(fm, pick_id(), FLAW_NONE, 0, $urandom_range(len - 1, 1));
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            ihd_pkg::REG_FM_MODE:    cfg_shadow.fm_mode          = v[0];
            ihd_pkg::REG_TGT_CYL:    cfg_shadow.target_cylinder  = v[7:0];
            ihd_pkg::REG_TGT_HEAD:   cfg_shadow.target_head      = v[7:0];
            ihd_pkg::REG_TGT_SECTOR: cfg_shadow.target_sector    = v[7:0];
            ihd_pkg::REG_TGT_SIZE:   cfg_shadow.target_size_code = v[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(input ihd_pkg::t_cfg c);
        apb_write(ihd_pkg::REG_FM_MODE,    {31'd0, c.fm_mode});
        apb_write(ihd_pkg::REG_TGT_CYL,    {24'd0, c.target_cylinder});
        apb_write(ihd_pkg::REG_TGT_HEAD,   {24'd0, c.target_head});
        apb_write(ihd_pkg::REG_TGT_SECTOR, {24'd0, c.target_sector});
        apb_write(ihd_pkg::REG_TGT_SIZE,   {24'd0, c.target_size_code});
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || tx_busy || expected_headers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_mismatch++;
        if (n_mismatch <= MAX_PRINTS)
            $display("%0t: report %0d %s: got 0x%0h, expected 0x%0h",
                     $time, n_reports, what, got, want);
    endtask

    // input side: transfer sampling and prediction
    always @(posedge i_clk) begin : in_sample
        ihd_pkg::t_in_item seen;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            seen = {in_if.func, in_if.data_byte, in_if.window_start, in_if.tick_stamp};
            decode_shadow(seen);
            in_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin : src_drive
        if (i_rst_n) begin
            if (in_taken) begin
                in_taken = 1'b0;
                tx_busy  = 1'b0;
            end
            if (!tx_busy && pending_items.size() != 0) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else begin
                    tx_item = pending_items.pop_front();
                    tx_busy = 1'b1;
                    tx_wait = draw_wait(src_steady);
                end
            end
            in_if.valid        <= tx_busy;
            in_if.func         <= tx_item.func;
            in_if.data_byte    <= tx_item.data_byte;
            in_if.window_start <= tx_item.window_start;
            in_if.tick_stamp   <= tx_item.tick_stamp;
        end
    end

    // output side: stall pattern and report checking
    always @(negedge i_clk) begin : sink_drive
        logic rdy;
        if (rx_hold > 0) begin
            rx_hold--;
            rdy = 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        out_if.ready <= rdy && i_rst_n;
    end

    always @(posedge i_clk) begin : out_check
        t_header_report want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            n_reports++;
            rx_wait = draw_wait(sink_steady);
            if (out_if.header_ok === 1'b1) n_ok++;
            if (out_if.target_match === 1'b1) n_match++;
            if (expected_headers.size() == 0) begin
                report_mismatch("unexpected report", 32'd1, 32'd0);
            end else begin
                want = expected_headers.pop_front();
                if (out_if.header_ok !== want.header_ok)
                    report_mismatch("header_ok", 32'(out_if.header_ok),
                                    32'(want.header_ok));
                if (out_if.target_match !== want.target_match)
                    report_mismatch("target_match", 32'(out_if.target_match),
                                    32'(want.target_match));
                if (out_if.cylinder !== want.cylinder)
                    report_mismatch("cylinder", 32'(out_if.cylinder), 32'(want.cylinder));
                if (out_if.head !== want.head)
                    report_mismatch("head", 32'(out_if.head), 32'(want.head));
                if (out_if.sector !== want.sector)
                    report_mismatch("sector", 32'(out_if.sector), 32'(want.sector));
                if (out_if.size_code !== want.size_code)
                    report_mismatch("size_code", 32'(out_if.size_code),
                                    32'(want.size_code));
                if (out_if.ticks_since_index !== want.ticks_since_index)
                    report_mismatch("ticks_since_index", out_if.ticks_since_index,
                                    want.ticks_since_index);
                if (out_if.header_count !== want.header_count)
                    report_mismatch("header_count", 32'(out_if.header_count),
                                    32'(want.header_count));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        ihd_pkg::t_cfg c;
        int            random_base;
        int            phase;
        in_if.valid        = 1'b0;
        in_if.func         = 1'b0;
        in_if.data_byte    = 8'h00;
        in_if.window_start = 1'b0;
        in_if.tick_stamp   = '0;
        out_if.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cfg_shadow         = '0;
        win_pos            = ihd_pkg::POS_IDLE;
        crc_acc            = ihd_pkg::CRC_INIT;
        marks_ok           = 1'b0;
        foreach (id_seen[k]) id_seen[k] = 8'h00;
        index_stamp        = '0;
        window_stamp       = '0;
        hdr_count          = '0;
        tick_now           = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: stray byte, header before any index, index near wrap,
        // restarted window with all-ones ID
        push_item(1'b0, 8'h5A, 1'b0);
        push_header(1'b0, 32'h0000_0000, FLAW_NONE, 0, 10);
        tick_now = 32'hFFFF_F000;
        push_item(1'b1, 8'hFF, 1'b1);
        push_item(1'b0, ihd_pkg::SYNC_MARK, 1'b1);
        push_item(1'b0, ihd_pkg::SYNC_MARK, 1'b0);
        push_header(1'b0, 32'hFFFF_FFFF, FLAW_NONE, 0, 10);
        wait_drained();

        // back-to-back run of good FM headers after an index pulse
        c = {1'b1, 32'($urandom())};
        write_config(c);
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        push_index();
        repeat (FM_RUN_HEADERS) push_header(1'b1, pick_id(), FLAW_NONE, 0, 8);
        wait_drained();

        // sink held off while the source keeps offering headers
        c = '0;
        write_config(c);
        rx_hold = HOLD_CYCLES;
        repeat (HOLD_HEADERS) push_header(1'b0, pick_id(), FLAW_NONE, 0, 10);
        wait_drained();

        random_base = n_used;
        phase       = 0;
        while (n_used - random_base < RANDOM_ITEMS) begin
            case (phase)
                0:       c = {1'b1, 32'h0000_0000};
                1:       c = {1'b0, 32'hFFFF_FFFF};
                2:       c = {1'b1, 32'hFFFF_FFFF};
                default: c = {1'($urandom_range(1, 0)), 32'($urandom())};
            endcase
            write_config(c);
            src_steady  = $urandom_range(3, 0) == 0;
            sink_steady = $urandom_range(3, 0) == 0;
            random_phase($urandom_range(200, 60));
            wait_drained();
            phase++;
        end

        $display("Checked %0d header reports (%0d valid, %0d on target) over %0d input transfers",
                 n_reports, n_ok, n_match, n_in);
        $display("in MFM and FM, incl. restarts, index and mode changes mid-window, %s",
                 "random stalls and a long sink hold-off.");
        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[ibm_sector_header_detector.f]
rtl/ihd_pkg.sv
rtl/ihd_if.sv
rtl/ihd_apb_regs.sv
rtl/ihd_in_stage.sv
rtl/ihd_core.sv
rtl/ibm_sector_header_detector.sv
tb/sv/ibm_sector_header_detector_tb.sv
